// ===== sv/quorum_transaction_tracker_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the quorum transaction tracker
// Shared property wrappers, clocked on the rising edge, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef QUORUM_TRANSACTION_TRACKER_DEFINES_SVH
`define QUORUM_TRANSACTION_TRACKER_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define QTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define QTT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/qtt_pkg.sv =====
// ---------------------------------------------------------------------------
// qtt_pkg
// Shared constants, codes and record types of the transaction tracker.
// ---------------------------------------------------------------------------
`default_nettype none

package qtt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // register indexes, taken from paddr[2]
  localparam logic REG_QUORUM  = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  localparam logic [1:0]  QUORUM_RST  = 2'd2;
  localparam logic [15:0] TIMEOUT_RST = 16'd10;

  localparam logic [1:0] COUNT_MAX = 2'd3;

  // input actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_REPLY = 2'd1;
  localparam logic [1:0] ACT_SWEEP = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_REPLY = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FAIL    = 3'd1;
  localparam logic [2:0] ST_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [15:0] id;
    logic [1:0]  op;
    logic [1:0]  good;
    logic [1:0]  bad;
    logic [15:0] start;
  } slot_rec_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] id;
    logic [1:0]  op;
    logic [2:0]  status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    vld;
    result_t res;
  } push_t;

  typedef struct packed {
    logic      we;
    idx_t      waddr;
    slot_rec_t wdata;
    idx_t      raddr;
  } ram_req_t;

endpackage

`default_nettype wire

// ===== sv/qtt_slot_ram.sv =====
// ---------------------------------------------------------------------------
// qtt_slot_ram
// Slot record memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module qtt_slot_ram (
  input  wire               clk,
  input  qtt_pkg::ram_req_t req,
  output qtt_pkg::slot_rec_t rd_data_r
);

  qtt_pkg::slot_rec_t mem_r [qtt_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem_r[req.raddr];
  end

endmodule

`default_nettype wire

// ===== sv/qtt_out_reg.sv =====
// ---------------------------------------------------------------------------
// qtt_out_reg
// Result output register; frees up as soon as the current transfer leaves.
// ---------------------------------------------------------------------------
`default_nettype none

module qtt_out_reg (
  input  wire              clk,
  input  wire              rst_n,
  input  qtt_pkg::push_t   push,
  output logic             push_rdy,
  output logic             out_valid,
  input  wire              out_stall,
  output qtt_pkg::result_t out_res
);

  logic             valid_r;
  qtt_pkg::result_t res_r;

  assign push_rdy  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push_rdy) begin
      valid_r <= push.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld && push_rdy) begin
      res_r <= push.res;
    end
  end

endmodule

`default_nettype wire

// ===== sv/qtt_engine.sv =====
// ---------------------------------------------------------------------------
// qtt_engine
// Item sequencer: slot allocation, id search and sweep over the slot memory.
// ---------------------------------------------------------------------------
`default_nettype none

module qtt_engine (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [1:0]          in_action,
  input  wire  [15:0]         in_trans_id,
  input  wire  [1:0]          in_op_kind,
  input  wire                 in_reply_ok,
  input  wire  [15:0]         in_current_time,
  input  wire  [1:0]          quorum,
  input  wire  [15:0]         timeout,
  input  wire                 push_rdy,
  output qtt_pkg::push_t      push,
  output qtt_pkg::ram_req_t   ram_req,
  input  qtt_pkg::slot_rec_t  rd_data
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_START = 3'b010,
    S_SCAN  = 3'b100
  } state_t;

  localparam int DEPTH = qtt_pkg::TABLE_DEPTH;
  localparam int IW    = qtt_pkg::IDX_W;
  localparam int CW    = qtt_pkg::CNT_W;

  state_t               state_r, state_nxt;
  logic [1:0]           act_r, act_nxt;
  logic [15:0]          id_r, id_nxt;
  logic [1:0]           op_r, op_nxt;
  logic                 ok_r, ok_nxt;
  logic [15:0]          now_r, now_nxt;
  logic [DEPTH-1:0]     valid_r, valid_nxt;
  logic [CW-1:0]        scan_r, scan_nxt;
  logic                 ev_vld_r, ev_vld_nxt;
  qtt_pkg::idx_t        ev_idx_r, ev_idx_nxt;
  logic                 pend_vld_r, pend_vld_nxt;
  qtt_pkg::result_t     pend_r, pend_nxt;

  logic                 free_found;
  qtt_pkg::idx_t        free_idx;
  logic                 cur_valid;
  logic [15:0]          elapsed;
  logic                 hit_good, hit_bad, hit_time;
  logic                 match, retire;
  logic [2:0]           ret_status;
  qtt_pkg::slot_rec_t   rec_upd;
  qtt_pkg::result_t     ret_res;
  logic                 hold;

  assign in_stall = (state_r != S_IDLE);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = qtt_pkg::idx_t'(i);
      end
    end
  end

  assign cur_valid = valid_r[ev_idx_r];
  assign elapsed   = now_r - rd_data.start;
  assign hit_good  = (rd_data.good >= quorum);
  assign hit_bad   = (rd_data.bad >= quorum);
  assign hit_time  = (elapsed >= timeout);
  assign match     = ev_vld_r && cur_valid && (rd_data.id == id_r);
  assign retire    = ev_vld_r && cur_valid && (hit_good || hit_bad || hit_time);

  always_comb begin
    if (hit_good) begin
      ret_status = qtt_pkg::ST_OK;
    end else if (hit_bad) begin
      ret_status = qtt_pkg::ST_FAIL;
    end else begin
      ret_status = qtt_pkg::ST_TIMEOUT;
    end
  end

  always_comb begin
    ret_res = '{kind: qtt_pkg::KIND_DONE, id: rd_data.id, op: rd_data.op,
                status: ret_status, last: 1'b0};
  end

  // saturating count update for a reply
  always_comb begin
    rec_upd = rd_data;
    if (ok_r) begin
      if (rd_data.good != qtt_pkg::COUNT_MAX) begin
        rec_upd.good = rd_data.good + 2'd1;
      end
    end else begin
      if (rd_data.bad != qtt_pkg::COUNT_MAX) begin
        rec_upd.bad = rd_data.bad + 2'd1;
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    id_nxt       = id_r;
    op_nxt       = op_r;
    ok_nxt       = ok_r;
    now_nxt      = now_r;
    valid_nxt    = valid_r;
    scan_nxt     = scan_r;
    ev_vld_nxt   = ev_vld_r;
    ev_idx_nxt   = ev_idx_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    hold         = 1'b0;
    push.vld     = 1'b0;
    push.res     = '0;
    ram_req.we    = 1'b0;
    ram_req.waddr = ev_idx_r;
    ram_req.wdata = rec_upd;
    ram_req.raddr = scan_r[IW-1:0];

    case (state_r)
      S_IDLE: begin
        ram_req.raddr = '0;
        if (in_valid) begin
          act_nxt      = in_action;
          id_nxt       = in_trans_id;
          op_nxt       = in_op_kind;
          ok_nxt       = in_reply_ok;
          now_nxt      = in_current_time;
          scan_nxt     = CW'(1);
          ev_vld_nxt   = 1'b1;
          ev_idx_nxt   = '0;
          pend_vld_nxt = 1'b0;
          case (in_action)
            qtt_pkg::ACT_START: state_nxt = S_START;
            qtt_pkg::ACT_REPLY: state_nxt = S_SCAN;
            qtt_pkg::ACT_SWEEP: state_nxt = S_SCAN;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end

      S_START: begin
        push.res = '{kind: qtt_pkg::KIND_START, id: id_r, op: op_r,
                     status: free_found ? qtt_pkg::ST_OK : qtt_pkg::ST_FULL,
                     last: 1'b1};
        if (push_rdy) begin
          push.vld = 1'b1;
          if (free_found) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = free_idx;
            ram_req.wdata = '{id: id_r, op: op_r, good: 2'd0, bad: 2'd0,
                              start: now_r};
            valid_nxt[free_idx] = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      S_SCAN: begin
        if (act_r == qtt_pkg::ACT_REPLY) begin
          if (match) begin
            push.res = '{kind: qtt_pkg::KIND_REPLY, id: id_r, op: rd_data.op,
                         status: qtt_pkg::ST_OK, last: 1'b1};
            if (push_rdy) begin
              push.vld   = 1'b1;
              ram_req.we = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              hold = 1'b1;
            end
          end else if (!ev_vld_r) begin
            push.res = '{kind: qtt_pkg::KIND_REPLY, id: id_r, op: 2'd0,
                         status: qtt_pkg::ST_UNKNOWN, last: 1'b1};
            if (push_rdy) begin
              push.vld  = 1'b1;
              state_nxt = S_IDLE;
            end
          end
        end else begin
          // sweep: keep one completion back so the final one can be marked last
          if (retire) begin
            if (pend_vld_r) begin
              push.res = pend_r;
              if (push_rdy) begin
                push.vld            = 1'b1;
                pend_nxt            = ret_res;
                valid_nxt[ev_idx_r] = 1'b0;
              end else begin
                hold = 1'b1;
              end
            end else begin
              pend_vld_nxt        = 1'b1;
              pend_nxt            = ret_res;
              valid_nxt[ev_idx_r] = 1'b0;
            end
          end else if (!ev_vld_r) begin
            if (pend_vld_r) begin
              push.res      = pend_r;
              push.res.last = 1'b1;
              if (push_rdy) begin
                push.vld     = 1'b1;
                pend_vld_nxt = 1'b0;
                state_nxt    = S_IDLE;
              end
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end

        // advance the read stream unless the current slot must be kept
        if (hold) begin
          ram_req.raddr = ev_idx_r;
        end else if (scan_r == CW'(DEPTH)) begin
          ev_vld_nxt = 1'b0;
        end else begin
          ev_vld_nxt = 1'b1;
          ev_idx_nxt = scan_r[IW-1:0];
          scan_nxt   = scan_r + CW'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      scan_r     <= '0;
      ev_vld_r   <= 1'b0;
      ev_idx_r   <= '0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      valid_r    <= valid_nxt;
      scan_r     <= scan_nxt;
      ev_vld_r   <= ev_vld_nxt;
      ev_idx_r   <= ev_idx_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    id_r   <= id_nxt;
    op_r   <= op_nxt;
    ok_r   <= ok_nxt;
    now_r  <= now_nxt;
    pend_r <= pend_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/quorum_transaction_tracker.sv =====
// ---------------------------------------------------------------------------
// quorum_transaction_tracker
// Outstanding-transaction table with quorum counting, timeout and sweep.
// ---------------------------------------------------------------------------
// A start transfer is accepted, then allocates the lowest free slot and hands
// back the acknowledge. A reply reads the slots in order until its id is found
// and reads every slot when the id is unknown; a sweep always reads every slot.
// The slot memory delivers one record per cycle through its single read port
// while the result channel does not stall; a stalled result channel can hold
// the item in work. One item is in work at a time, and a finished result waits
// in the output register while the next item is accepted. Slot contents are
// kept in memory without a clearing pass: per-slot valid flags reset to
// empty, so the block takes items as soon as reset is released.
// ---------------------------------------------------------------------------
`default_nettype none

`include "quorum_transaction_tracker_defines.svh"

module quorum_transaction_tracker (
  input  wire                          clk,
  input  wire                          rst_n,

  // item input
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [1:0]                   in_action,
  input  wire  [15:0]                  in_trans_id,
  input  wire  [1:0]                   in_op_kind,
  input  wire                          in_reply_ok,
  input  wire  [15:0]                  in_current_time,

  // result output
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [1:0]                   out_result_kind,
  output logic [15:0]                  out_done_id,
  output logic [1:0]                   out_done_op,
  output logic [2:0]                   out_status,
  output logic                         out_last_result,

  // register port
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [qtt_pkg::ADDR_W-1:0]   paddr,
  input  wire  [qtt_pkg::DATA_W-1:0]   pwdata,
  output logic [qtt_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  logic [1:0]          quorum_r;
  logic [15:0]         timeout_r;
  logic                cfg_wr;

  qtt_pkg::push_t      push;
  logic                push_rdy;
  qtt_pkg::ram_req_t   ram_req;
  qtt_pkg::slot_rec_t  rd_data;
  qtt_pkg::result_t    out_res;

  // Register file: pready is always high, so writes never wait; paddr[2] picks the register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quorum_r  <= qtt_pkg::QUORUM_RST;
      timeout_r <= qtt_pkg::TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        qtt_pkg::REG_QUORUM:  quorum_r  <= pwdata[1:0];
        qtt_pkg::REG_TIMEOUT: timeout_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      qtt_pkg::REG_QUORUM:  prdata = {{(qtt_pkg::DATA_W - 2){1'b0}}, quorum_r};
      qtt_pkg::REG_TIMEOUT: prdata = {{(qtt_pkg::DATA_W - 16){1'b0}}, timeout_r};
      default:              prdata = '0;
    endcase
  end

  // Sequencer: allocate on start, search by id on reply, retire on sweep.
  qtt_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_trans_id     (in_trans_id),
    .in_op_kind      (in_op_kind),
    .in_reply_ok     (in_reply_ok),
    .in_current_time (in_current_time),
    .quorum          (quorum_r),
    .timeout         (timeout_r),
    .push_rdy        (push_rdy),
    .push            (push),
    .ram_req         (ram_req),
    .rd_data         (rd_data)
  );

  // Slot records: id, op, saturating reply counts and start time.
  qtt_slot_ram u_ram (
    .clk       (clk),
    .req       (ram_req),
    .rd_data_r (rd_data)
  );

  // Hold one result for the downstream transfer.
  qtt_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rdy  (push_rdy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_result_kind = out_res.kind;
  assign out_done_id     = out_res.id;
  assign out_done_op     = out_res.op;
  assign out_status      = out_res.status;
  assign out_last_result = out_res.last;

  // Any real item must keep the input closed for at least the next cycle.
  `QTT_ASSERT_NXT(a_item_busy, clk, rst_n,
    in_valid && !in_stall && ((in_action == qtt_pkg::ACT_START) ||
    (in_action == qtt_pkg::ACT_REPLY) || (in_action == qtt_pkg::ACT_SWEEP)), in_stall,
    "input taken again right after an item was accepted")

  // Start and reply produce exactly one result, so it is always the last.
  `QTT_ASSERT_IMP(a_single_last, clk, rst_n,
    out_valid && (out_result_kind != qtt_pkg::KIND_DONE), out_last_result,
    "acknowledge result not marked last")

  // A start acknowledge only reports accepted or table full.
  `QTT_ASSERT_IMP(a_start_status, clk, rst_n,
    out_valid && (out_result_kind == qtt_pkg::KIND_START),
    (out_status == qtt_pkg::ST_OK) || (out_status == qtt_pkg::ST_FULL),
    "bad status on start acknowledge")

  // Completions carry only success, failure or timeout.
  `QTT_ASSERT_IMP(a_done_status, clk, rst_n,
    out_valid && (out_result_kind == qtt_pkg::KIND_DONE),
    (out_status == qtt_pkg::ST_OK) || (out_status == qtt_pkg::ST_FAIL) ||
    (out_status == qtt_pkg::ST_TIMEOUT),
    "bad status on completion")

endmodule

`default_nettype wire

// ===== tb/quorum_transaction_tracker_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quorum_transaction_tracker_checker
// Watches the item, result and register ports of the tracker, keeps its own
// copy of the transaction table, predicts every result and compares them.
// ---------------------------------------------------------------------------
module quorum_transaction_tracker_checker (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  input  wire                          in_stall,
  input  wire  [1:0]                   in_action,
  input  wire  [15:0]                  in_trans_id,
  input  wire  [1:0]                   in_op_kind,
  input  wire                          in_reply_ok,
  input  wire  [15:0]                  in_current_time,
  input  wire                          out_valid,
  input  wire                          out_stall,
  input  wire  [1:0]                   out_result_kind,
  input  wire  [15:0]                  out_done_id,
  input  wire  [1:0]                   out_done_op,
  input  wire  [2:0]                   out_status,
  input  wire                          out_last_result,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [qtt_pkg::ADDR_W-1:0]   paddr,
  input  wire  [qtt_pkg::DATA_W-1:0]   pwdata,
  input  wire                          pready,
  output int                           mismatch_count,
  output int                           results_outstanding,
  output int                           results_checked
);

  localparam int PRINT_LIMIT = 40;

  logic [1:0]  quorum_reg;
  logic [15:0] timeout_reg;

  logic        slot_busy [qtt_pkg::TABLE_DEPTH];
  logic [15:0] slot_tid  [qtt_pkg::TABLE_DEPTH];
  logic [1:0]  slot_op   [qtt_pkg::TABLE_DEPTH];
  logic [1:0]  slot_good [qtt_pkg::TABLE_DEPTH];
  logic [1:0]  slot_bad  [qtt_pkg::TABLE_DEPTH];
  logic [15:0] slot_t0   [qtt_pkg::TABLE_DEPTH];

  qtt_pkg::result_t awaited_results [$];

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] mismatch, %s: expected %0h, got %0h", $time, what, want, got);
    mismatch_count++;
  endtask

  // Update the table for one accepted transfer and queue the results it causes.
  task automatic track_transfer(input logic [1:0] act, input logic [15:0] tid,
                                input logic [1:0] op, input logic ok,
                                input logic [15:0] now);
    qtt_pkg::result_t r;
    qtt_pkg::result_t produced [$];
    int               hit;
    logic [15:0]      elapsed;
    logic             retire;
    hit = -1;
    r   = '0;
    case (act)
      qtt_pkg::ACT_START: begin
        for (int i = 0; i < qtt_pkg::TABLE_DEPTH; i++)
          if (!slot_busy[i] && hit < 0) hit = i;
        r.kind = qtt_pkg::KIND_START;
        r.id   = tid;
        r.op   = op;
        if (hit < 0) begin
          r.status = qtt_pkg::ST_FULL;
        end else begin
          slot_busy[hit] = 1'b1;
          slot_tid[hit]  = tid;
          slot_op[hit]   = op;
          slot_good[hit] = '0;
          slot_bad[hit]  = '0;
          slot_t0[hit]   = now;
          r.status       = qtt_pkg::ST_OK;
        end
        produced.insert(produced.size(), r);
      end
      qtt_pkg::ACT_REPLY: begin
        for (int i = 0; i < qtt_pkg::TABLE_DEPTH; i++)
          if (slot_busy[i] && slot_tid[i] == tid && hit < 0) hit = i;
        r.kind = qtt_pkg::KIND_REPLY;
        r.id   = tid;
        if (hit < 0) begin
          r.op     = '0;
          r.status = qtt_pkg::ST_UNKNOWN;
        end else begin
          // counts saturate rather than wrap
          if (ok) begin
            if (slot_good[hit] < qtt_pkg::COUNT_MAX) slot_good[hit]++;
          end else begin
            if (slot_bad[hit] < qtt_pkg::COUNT_MAX) slot_bad[hit]++;
          end
          r.op     = slot_op[hit];
          r.status = qtt_pkg::ST_OK;
        end
        produced.insert(produced.size(), r);
      end
      qtt_pkg::ACT_SWEEP: begin
        for (int i = 0; i < qtt_pkg::TABLE_DEPTH; i++) begin
          if (slot_busy[i]) begin
            elapsed = now - slot_t0[i];
            retire  = 1'b1;
            if (slot_good[i] >= quorum_reg)     r.status = qtt_pkg::ST_OK;
            else if (slot_bad[i] >= quorum_reg) r.status = qtt_pkg::ST_FAIL;
            else if (elapsed >= timeout_reg)    r.status = qtt_pkg::ST_TIMEOUT;
            else                                retire = 1'b0;
            if (retire) begin
              r.kind       = qtt_pkg::KIND_DONE;
              r.id         = slot_tid[i];
              r.op         = slot_op[i];
              r.last       = 1'b0;
              slot_busy[i] = 1'b0;
              produced.insert(produced.size(), r);
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (produced.size() > 0) begin
      r      = produced.pop_back();
      r.last = 1'b1;
      produced.insert(produced.size(), r);
    end
    foreach (produced[k]) awaited_results.insert(awaited_results.size(), produced[k]);
  endtask

  task automatic check_result();
    qtt_pkg::result_t want;
    if (awaited_results.size() == 0) begin
      report("result with nothing awaited, id", '0, 32'(out_done_id));
    end else begin
      want = awaited_results.pop_front();
      if (out_result_kind !== want.kind)
        report("result_kind", 32'(want.kind), 32'(out_result_kind));
      if (out_done_id !== want.id)
        report("done_id", 32'(want.id), 32'(out_done_id));
      if (out_done_op !== want.op)
        report("done_op", 32'(want.op), 32'(out_done_op));
      if (out_status !== want.status)
        report("status", 32'(want.status), 32'(out_status));
      if (out_last_result !== want.last)
        report("last_result", 32'(want.last), 32'(out_last_result));
      results_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      quorum_reg      = qtt_pkg::QUORUM_RST;
      timeout_reg     = qtt_pkg::TIMEOUT_RST;
      mismatch_count  = 0;
      results_checked = 0;
      awaited_results.delete();
      for (int i = 0; i < qtt_pkg::TABLE_DEPTH; i++) slot_busy[i] = 1'b0;
    end else begin
      // A result can never belong to the item taken at the same edge.
      if (out_valid === 1'b1 && out_stall === 1'b0) check_result();
      if (in_valid === 1'b1 && in_stall === 1'b0)
        track_transfer(in_action, in_trans_id, in_op_kind, in_reply_ok, in_current_time);
      if (psel === 1'b1 && penable === 1'b1 && pwrite === 1'b1 && pready === 1'b1) begin
        if (paddr[2] == qtt_pkg::REG_TIMEOUT) timeout_reg = pwdata[15:0];
        else                                  quorum_reg  = pwdata[1:0];
      end
    end
    results_outstanding = awaited_results.size();
  end

endmodule

// ===== tb/quorum_transaction_tracker_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quorum_transaction_tracker_tb
// Stimulus and verdict for the quorum transaction tracker.
// Sends directed and random start, reply and sweep transfers with random
// sender gaps and receiver stalls, steps the quorum and timeout registers
// through several settings between idle phases, and takes the mismatch count
// from the checker that sits beside the block.
// ---------------------------------------------------------------------------
module quorum_transaction_tracker_tb;

  localparam int LIMIT_CYCLES  = 500000;
  // slowest item (sweep or unknown-id reply) with room to spare
  localparam int SETTLE_CYCLES = 2 * (qtt_pkg::TABLE_DEPTH + 2);
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 14;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_DELETE = 2'd3;

  localparam logic [qtt_pkg::ADDR_W-1:0] QUORUM_ADDR  = {qtt_pkg::REG_QUORUM, 2'b00};
  localparam logic [qtt_pkg::ADDR_W-1:0] TIMEOUT_ADDR = {qtt_pkg::REG_TIMEOUT, 2'b00};

  // -------------------------------------------------------------------------
  // Block ports; every input starts at a known value
  // -------------------------------------------------------------------------
  logic                       clk             = 1'b0;
  logic                       rst_n           = 1'b0;
  logic                       in_valid        = 1'b0;
  logic                       in_stall;
  logic [1:0]                 in_action       = '0;
  logic [15:0]                in_trans_id     = '0;
  logic [1:0]                 in_op_kind      = '0;
  logic                       in_reply_ok     = 1'b0;
  logic [15:0]                in_current_time = '0;
  logic                       out_valid;
  logic                       out_stall       = 1'b0;
  logic [1:0]                 out_result_kind;
  logic [15:0]                out_done_id;
  logic [1:0]                 out_done_op;
  logic [2:0]                 out_status;
  logic                       out_last_result;
  logic                       psel            = 1'b0;
  logic                       penable         = 1'b0;
  logic                       pwrite          = 1'b0;
  logic [qtt_pkg::ADDR_W-1:0] paddr           = '0;
  logic [qtt_pkg::DATA_W-1:0] pwdata          = '0;
  logic [qtt_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  int mismatch_count;
  int results_outstanding;
  int results_checked;

  // sender bookkeeping
  int          burst_left       = 0;
  bit          steady_flow      = 1'b0;
  logic [15:0] clock_now        = '0;
  logic [15:0] live_ids [$];
  int          items_sent       = 0;
  int          settings_applied = 0;

  // receiver stall pattern
  int          stall_mode = 0;
  int          mode_left  = 0;

  int unsigned cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quorum_transaction_tracker uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_trans_id     (in_trans_id),
    .in_op_kind      (in_op_kind),
    .in_reply_ok     (in_reply_ok),
    .in_current_time (in_current_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_done_id     (out_done_id),
    .out_done_op     (out_done_op),
    .out_status      (out_status),
    .out_last_result (out_last_result),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  quorum_transaction_tracker_checker tracker_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_trans_id         (in_trans_id),
    .in_op_kind          (in_op_kind),
    .in_reply_ok         (in_reply_ok),
    .in_current_time     (in_current_time),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_done_id         (out_done_id),
    .out_done_op         (out_done_op),
    .out_status          (out_status),
    .out_last_result     (out_last_result),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .pready              (pready),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding),
    .results_checked     (results_checked)
  );

  // -------------------------------------------------------------------------
  // Watchdog: end the run if it hangs
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_count, results_outstanding);
      $display("TEST FAILED");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: switch between free flow, light and heavy stalling, each mode
  // held for a random stretch so stalls land on every phase of a sweep.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_mode <= 0;
      mode_left  <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(20, 150);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Sender
  // -------------------------------------------------------------------------

  // Present one item and hold it until the transfer happens. Between bursts,
  // drop valid for a random gap unless the phase runs steady.
  task automatic send_item(input logic [1:0] act, input logic [15:0] tid,
                           input logic [1:0] op, input logic ok,
                           input logic [15:0] now);
    int gap;
    in_valid        <= 1'b1;
    in_action       <= act;
    in_trans_id     <= tid;
    in_op_kind      <= op;
    in_reply_ok     <= ok;
    in_current_time <= now;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 10);
      if (!steady_flow) begin
        // mostly short gaps, sometimes long enough to cover a whole sweep
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Pause until every awaited result has been taken, then let a possible
  // result-free sweep run out before anything touches the registers.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, access cycle until pready, then the bus returns
  // to idle before the next write may start.
  task automatic cfg_write(input logic [qtt_pkg::ADDR_W-1:0] addr,
                           input logic [qtt_pkg::DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [1:0] quorum, input logic [15:0] ticks);
    cfg_write(QUORUM_ADDR, qtt_pkg::DATA_W'(quorum));
    cfg_write(TIMEOUT_ADDR, qtt_pkg::DATA_W'(ticks));
    settings_applied++;
  endtask

  // Random traffic: mostly starts and replies to live ids so counts build up
  // toward the quorum, sweeps with a slowly advancing clock, and some noise
  // (stray ids, time jumps, the unused action).
  task automatic run_traffic(input int count, input bit steady);
    int          roll;
    logic [1:0]  act;
    logic [15:0] tid;
    steady_flow = steady;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 6) == 0) clock_now = 16'($urandom);
      else                           clock_now = clock_now + 16'($urandom_range(0, 3));
      tid = 16'($urandom);
      if (roll < 35) begin
        act = qtt_pkg::ACT_START;
        // reuse a live id now and then to make duplicates
        if (live_ids.size() > 0 && $urandom_range(0, 3) == 0)
          tid = live_ids[$urandom_range(0, live_ids.size() - 1)];
        live_ids.insert(live_ids.size(), tid);
        if (live_ids.size() > 8) void'(live_ids.pop_front());
      end else if (roll < 75) begin
        act = qtt_pkg::ACT_REPLY;
        if (live_ids.size() > 0 && $urandom_range(0, 4) != 0)
          tid = live_ids[$urandom_range(0, live_ids.size() - 1)];
      end else if (roll < 95) begin
        act = qtt_pkg::ACT_SWEEP;
      end else begin
        act = ACT_UNUSED;
      end
      send_item(act, tid, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), clock_now);
    end
    steady_flow = 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  logic [1:0]  quorum_plan  [PHASES] = '{2'd1, 2'd3, 2'd0, 2'd3, 2'd1, 2'd2};
  logic [15:0] timeout_plan [PHASES] = '{16'd1, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd10};

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset settings (quorum 2, timeout 10).
    // Extreme ids, times and every op; ignored fields on a reply carry junk.
    send_item(qtt_pkg::ACT_START, 16'h0000, OP_CREATE, 1'b0, 16'h0000);
    send_item(qtt_pkg::ACT_START, 16'hFFFF, OP_DELETE, 1'b1, 16'hFFFF);
    send_item(qtt_pkg::ACT_REPLY, 16'h0000, OP_DELETE, 1'b1, 16'hFFFF);
    send_item(qtt_pkg::ACT_REPLY, 16'h0000, OP_CREATE, 1'b1, 16'h0000);
    // four failures: the count must saturate at three, not wrap to zero
    repeat (4) send_item(qtt_pkg::ACT_REPLY, 16'hFFFF, OP_READ, 1'b0, 16'h0000);
    // reply to an id that is not in the table
    send_item(qtt_pkg::ACT_REPLY, 16'h1234, OP_UPDATE, 1'b1, 16'h0001);
    // duplicate id: accepted, replies still go to the lowest slot
    send_item(qtt_pkg::ACT_START, 16'h0000, OP_UPDATE, 1'b0, 16'h0005);
    send_item(qtt_pkg::ACT_REPLY, 16'h0000, OP_READ, 1'b0, 16'h0005);
    send_item(qtt_pkg::ACT_START, 16'h00A5, OP_READ, 1'b0, 16'h0001);
    send_item(ACT_UNUSED, 16'hFFFF, OP_DELETE, 1'b1, 16'hFFFF);
    // sweep at 3: quorum success, quorum failure, and a wrapped-time timeout;
    // the entry started at 1 stays open
    send_item(qtt_pkg::ACT_SWEEP, 16'h0000, OP_CREATE, 1'b0, 16'h0003);
    // sweep with a live but unfinished entry: no result at all
    send_item(qtt_pkg::ACT_SWEEP, 16'hFFFF, OP_CREATE, 1'b0, 16'h0004);
    clock_now = 16'h0004;
    live_ids.insert(live_ids.size(), 16'h00A5);
    drain_results();

    // Fill the table past capacity so a start sees it full, then reply three times
    // to one entry and sweep far ahead to empty it.
    repeat (qtt_pkg::TABLE_DEPTH + 1) begin
      clock_now = clock_now + 16'($urandom_range(0, 2));
      send_item(qtt_pkg::ACT_START, 16'($urandom), 2'($urandom_range(0, 3)), 1'b0,
                clock_now);
    end
    repeat (3)
      send_item(qtt_pkg::ACT_REPLY, 16'h00A5, OP_CREATE, 1'($urandom_range(0, 1)),
                clock_now);
    clock_now = clock_now + 16'd200;
    send_item(qtt_pkg::ACT_SWEEP, 16'($urandom), 2'($urandom_range(0, 3)), 1'b0,
              clock_now);
    drain_results();

    // Random phases, one register setting each, extremes included; the last
    // setting is drawn at random. Every third phase runs without sender gaps.
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        quorum_plan[p]  = 2'($urandom_range(1, 3));
        timeout_plan[p] = 16'($urandom_range(1, 65535));
      end
      apply_setting(quorum_plan[p], timeout_plan[p]);
      run_traffic(PHASE_ITEMS, (p % 3) == 1);
      drain_results();
    end

    @(negedge clk);
    $display("Covered %0d input transfers and %0d checked results over %0d register settings",
             items_sent, results_checked, settings_applied);
    $display("Included table overflow, saturated counts, unknown ids, zero quorum and timeout");
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
